>>> rtl/core/pesp_pkg.sv
// ----------------------------------------------------------------------------
// pesp_pkg
// Shared types and constants of the printer escape-sequence parser.
// ----------------------------------------------------------------------------
`default_nettype none

package pesp_pkg;

  localparam logic [7:0] ESC_BYTE = 8'h1B;
  localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;
  localparam logic [31:0] POS_LIMIT = 32'h7FFF_FFFF;

  // Result kinds
  localparam logic [3:0] KIND_TEXT     = 4'd0;
  localparam logic [3:0] KIND_PLOT     = 4'd1;
  localparam logic [3:0] KIND_ESC      = 4'd2;
  localparam logic [3:0] KIND_TWO_BYTE = 4'd3;
  localparam logic [3:0] KIND_PREFIX   = 4'd4;
  localparam logic [3:0] KIND_GROUP    = 4'd5;
  localparam logic [3:0] KIND_VALUE    = 4'd6;
  localparam logic [3:0] KIND_CMD_DONE = 4'd7;
  localparam logic [3:0] KIND_BAD      = 4'd8;
  localparam logic [3:0] KIND_SKIP     = 4'd9;

  // Parser states
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_ESC    = 2'd1;
  localparam logic [1:0] ST_PREFIX = 2'd2;
  localparam logic [1:0] ST_VALUE  = 2'd3;

  // Stream modes
  localparam logic [1:0] MODE_TEXT = 2'd0;
  localparam logic [1:0] MODE_PLOT = 2'd1;
  localparam logic [1:0] MODE_JOB  = 2'd2;

  localparam logic [4:0] MAX_VALUE_CHARS = 5'd31;

  typedef struct packed {
    logic [3:0]         kind;
    logic [7:0]         echo_byte;
    logic               aborted;
    logic [7:0]         prefix_char;
    logic [7:0]         group_char;
    logic [7:0]         term_char;
    logic signed [31:0] value;
    logic               chained;
    logic [30:0]        payload_count;
    logic [31:0]        run_length;
    logic [1:0]         stream_mode;
  } res_t;

  function automatic logic is_transfer(input logic [7:0] p, input logic [7:0] g,
                                       input logic [7:0] t);
    return (p == ")" && g == "s" && t == "W") || (p == "(" && g == "s" && t == "W") ||
           (p == "(" && g == "f" && t == "W") || (p == "*" && g == "b" && t == "W") ||
           (p == "*" && g == "c" && t == "W") || (p == "&" && g == "p" && t == "X");
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/printer_escape_sequence_parser_unit.sv
// ----------------------------------------------------------------------------
// printer_escape_sequence_parser_unit
// Classifies a printer byte stream one byte per request.
//
//   channel   handshake                    payload
//   input     data_valid / data_ready      data_byte
//   output    result_valid / result_ready  kind .. stream_mode (one per byte)
//
// One byte per clock sustained while results are taken; each byte passes two
// registers before its result is valid: it waits in the input register and
// the parse step then writes the result register.
// Reset clears all parser state at once, no clearing pass.
// A stalled result holds in the result register; the input register still
// takes one more byte, then data_ready drops until the result moves on.
// ----------------------------------------------------------------------------
`default_nettype none

module printer_escape_sequence_parser_unit
  import pesp_pkg::*;
#(
  parameter int RUN_BITS = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               data_valid,
  output logic                    data_ready,
  input  wire logic [7:0]         data_byte,
  output logic                    result_valid,
  input  wire logic               result_ready,
  output logic [3:0]              kind,
  output logic [7:0]              echo_byte,
  output logic                    aborted,
  output logic [7:0]              prefix_char,
  output logic [7:0]              group_char,
  output logic [7:0]              term_char,
  output logic signed [31:0]      value,
  output logic                    chained,
  output logic [30:0]             payload_count,
  output logic [31:0]             run_length,
  output logic [1:0]              stream_mode
);

  logic       in_full;
  logic [7:0] in_byte;
  logic       advance;
  res_t       res_next;
  res_t       res_q;

  assign advance    = in_full && (!result_valid || result_ready);
  assign data_ready = !in_full || advance;

  pesp_parser #(
    .RUN_BITS (RUN_BITS)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .data_byte (in_byte),
    .res       (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (data_valid && data_ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (data_valid && data_ready) in_byte <= data_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) res_q <= res_next;
  end

  assign kind          = res_q.kind;
  assign echo_byte     = res_q.echo_byte;
  assign aborted       = res_q.aborted;
  assign prefix_char   = res_q.prefix_char;
  assign group_char    = res_q.group_char;
  assign term_char     = res_q.term_char;
  assign value         = res_q.value;
  assign chained       = res_q.chained;
  assign payload_count = res_q.payload_count;
  assign run_length    = res_q.run_length;
  assign stream_mode   = res_q.stream_mode;

`ifndef SYNTHESIS
  a_payload_only_on_done: assert property (@(posedge clk) disable iff (rst)
    result_valid && kind != KIND_CMD_DONE |-> payload_count == 31'd0)
    else $error("payload count outside a completed command");

  a_run_only_on_esc: assert property (@(posedge clk) disable iff (rst)
    result_valid && kind != KIND_ESC |-> run_length == 32'd0)
    else $error("run length outside an escape");

  a_input_holds: assert property (@(posedge clk) disable iff (rst)
    in_full && !advance |=> in_full && $stable(in_byte))
    else $error("input register lost a pending byte");

  a_abort_is_esc: assert property (@(posedge clk) disable iff (rst)
    result_valid && aborted |-> kind == KIND_ESC && echo_byte == ESC_BYTE)
    else $error("abort flagged on a non-escape result");
`endif

endmodule

`default_nettype wire

>>> rtl/core/pesp_value_unit.sv
// ----------------------------------------------------------------------------
// pesp_value_unit
// Decimal accumulate step and signed, saturated value of the argument.
// ----------------------------------------------------------------------------
`default_nettype none

module pesp_value_unit
  import pesp_pkg::*;
(
  input  wire logic [31:0]        acc,
  input  wire logic               negative,
  input  wire logic [3:0]         digit,
  output logic [31:0]             acc_digit,
  output logic signed [31:0]      value
);

  logic [34:0] prod;

  // acc * 10 + digit as two shifts and two adds
  assign prod = ({3'b000, acc} << 3) + ({3'b000, acc} << 1) + {31'd0, digit};

  always_comb begin
    if (prod > {3'b000, MAG_LIMIT}) begin
      acc_digit = MAG_LIMIT;
    end else begin
      acc_digit = prod[31:0];
    end

    if (negative) begin
      value = (acc >= MAG_LIMIT) ? MAG_LIMIT : (32'd0 - acc);
    end else begin
      value = (acc > POS_LIMIT) ? POS_LIMIT : acc;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/pesp_parser.sv
// ----------------------------------------------------------------------------
// pesp_parser
// Parse state registers and the per-byte classification step.
// ----------------------------------------------------------------------------
`default_nettype none

module pesp_parser
  import pesp_pkg::*;
#(
  parameter int RUN_BITS = 32
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step,
  input  wire logic [7:0] data_byte,
  output res_t            res
);

  logic [1:0]          parse_state, parse_state_next;
  logic [1:0]          mode_reg, mode_reg_next;
  logic [30:0]         skip_left, skip_left_next;
  logic [RUN_BITS-1:0] text_run, text_run_next;
  logic [7:0]          held_prefix, held_prefix_next;
  logic [7:0]          held_group, held_group_next;
  logic [31:0]         value_acc, value_acc_next;
  logic                value_negative, value_negative_next;
  logic [4:0]          chars_seen, chars_seen_next;
  logic                dot_seen, dot_seen_next;

  logic [1:0]          cur_state;
  logic [31:0]         cur_acc;
  logic                cur_neg;
  logic [4:0]          cur_chars;
  logic                cur_dot;
  logic [31:0]         acc_digit;
  logic signed [31:0]  arg_value;
  logic [64:0]         run_wide;
  logic [7:0]          b;
  logic                b_lower, b_upper, b_digit, b_sign;
  logic [7:0]          term;

  assign b       = data_byte;
  assign b_lower = (b >= "a") && (b <= "z");
  assign b_upper = (b >= "A") && (b <= "Z");
  assign b_digit = (b >= "0") && (b <= "9");
  assign b_sign  = (b == "+") || (b == "-");
  assign term    = b_lower ? (b - 8'd32) : b;

  // An escape outside a payload skip aborts any open sequence and restarts as a fresh escape
  assign cur_state = (b == ESC_BYTE && parse_state != ST_IDLE) ? ST_IDLE : parse_state;

  // A new prefix starts the value from scratch
  assign cur_acc   = (cur_state == ST_PREFIX) ? 32'd0 : value_acc;
  assign cur_neg   = (cur_state == ST_PREFIX) ? 1'b0 : value_negative;
  assign cur_chars = (cur_state == ST_PREFIX) ? 5'd0 : chars_seen;
  assign cur_dot   = (cur_state == ST_PREFIX) ? 1'b0 : dot_seen;

  assign run_wide = 65'(text_run);

  pesp_value_unit u_value (
    .acc       (cur_acc),
    .negative  (cur_neg),
    .digit     (b[3:0]),
    .acc_digit (acc_digit),
    .value     (arg_value)
  );

  always_comb begin
    parse_state_next    = parse_state;
    mode_reg_next       = mode_reg;
    skip_left_next      = skip_left;
    text_run_next       = text_run;
    held_prefix_next    = held_prefix;
    held_group_next     = held_group;
    value_acc_next      = value_acc;
    value_negative_next = value_negative;
    chars_seen_next     = chars_seen;
    dot_seen_next       = dot_seen;
    res                 = '0;
    res.echo_byte       = b;

    if (skip_left != 31'd0) begin
      skip_left_next = skip_left - 31'd1;
      res.kind       = KIND_SKIP;
    end else begin
      if (b == ESC_BYTE && parse_state != ST_IDLE) begin
        res.aborted = 1'b1;
      end

      case (cur_state)
        ST_IDLE: begin
          if (b != ESC_BYTE) begin
            if (mode_reg == MODE_PLOT) begin
              res.kind = KIND_PLOT;
            end else begin
              if (text_run != '1) text_run_next = text_run + {{(RUN_BITS-1){1'b0}}, 1'b1};
              res.kind = KIND_TEXT;
            end
          end else begin
            if (mode_reg != MODE_PLOT) begin
              res.run_length = (run_wide[64:32] != '0) ? 32'hFFFF_FFFF : run_wide[31:0];
              text_run_next  = '0;
            end
            parse_state_next = ST_ESC;
            res.kind         = KIND_ESC;
          end
        end
        ST_ESC: begin
          held_prefix_next    = b;
          held_group_next     = 8'd0;
          value_acc_next      = 32'd0;
          value_negative_next = 1'b0;
          chars_seen_next     = 5'd0;
          dot_seen_next       = 1'b0;
          if (b inside {"$", "%", "&", "(", ")", "*"}) begin
            parse_state_next = ST_PREFIX;
            res.kind         = KIND_PREFIX;
          end else begin
            parse_state_next = ST_IDLE;
            res.kind         = KIND_TWO_BYTE;
          end
        end
        default: begin
          value_acc_next      = cur_acc;
          value_negative_next = cur_neg;
          chars_seen_next     = cur_chars;
          dot_seen_next       = cur_dot;
          if (cur_state == ST_PREFIX && b_lower) begin
            held_group_next  = b;
            parse_state_next = ST_VALUE;
            res.kind         = KIND_GROUP;
          end else if (b_digit || b_sign || b == ".") begin
            if (cur_chars != 5'd0 && b_sign) begin
              parse_state_next = ST_IDLE;
              res.kind         = KIND_BAD;
            end else begin
              if (cur_chars < MAX_VALUE_CHARS) begin
                if (b == "-") value_negative_next = 1'b1;
                else if (b == ".") dot_seen_next = 1'b1;
                else if (b_digit && !cur_dot) value_acc_next = acc_digit;
                chars_seen_next = cur_chars + 5'd1;
              end
              parse_state_next = ST_VALUE;
              res.kind         = KIND_VALUE;
            end
          end else if (b_lower || b_upper || b == "@") begin
            res.term_char = term;
            res.value     = arg_value;
            if (is_transfer(held_prefix, held_group, term) && !cur_neg && cur_acc != 32'd0)
            begin
              skip_left_next    = arg_value[30:0];
              res.payload_count = arg_value[30:0];
            end
            if (held_prefix == "%" && held_group == 8'd0) begin
              if (term == "X") mode_reg_next = MODE_JOB;
              else if (term == "A") mode_reg_next = MODE_TEXT;
              else if (term == "B") mode_reg_next = MODE_PLOT;
            end
            res.chained         = b_lower;
            parse_state_next    = b_lower ? ST_VALUE : ST_IDLE;
            res.kind            = KIND_CMD_DONE;
            value_acc_next      = 32'd0;
            value_negative_next = 1'b0;
            chars_seen_next     = 5'd0;
            dot_seen_next       = 1'b0;
          end else begin
            parse_state_next = ST_IDLE;
            res.kind         = KIND_BAD;
          end
        end
      endcase

      if (res.kind >= KIND_TWO_BYTE && res.kind <= KIND_BAD) res.prefix_char = held_prefix_next;
      if (res.kind >= KIND_GROUP && res.kind <= KIND_BAD) res.group_char = held_group_next;
    end

    res.stream_mode = mode_reg_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_state    <= ST_IDLE;
      mode_reg       <= MODE_TEXT;
      skip_left      <= '0;
      text_run       <= '0;
      held_prefix    <= '0;
      held_group     <= '0;
      value_acc      <= '0;
      value_negative <= 1'b0;
      chars_seen     <= '0;
      dot_seen       <= 1'b0;
    end else if (step) begin
      parse_state    <= parse_state_next;
      mode_reg       <= mode_reg_next;
      skip_left      <= skip_left_next;
      text_run       <= text_run_next;
      held_prefix    <= held_prefix_next;
      held_group     <= held_group_next;
      value_acc      <= value_acc_next;
      value_negative <= value_negative_next;
      chars_seen     <= chars_seen_next;
      dot_seen       <= dot_seen_next;
    end
  end

endmodule

`default_nettype wire
